>>> src/sdd_pkg.sv
`timescale 1ns / 1ps
package sdd_pkg;

	localparam int VAL_W = 32;
	localparam int MAX_DEPTH = 32;
	localparam int IDX_W = $clog2(MAX_DEPTH);
	localparam int CNT_W = $clog2(MAX_DEPTH + 1);
	localparam int DEF_DEPTH_A = 16;
	localparam int DEF_DEPTH_B = 16;

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic                    is_empty;
		logic                    overflowed;
		logic                    last_of_run;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic             from_b;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
		logic             kill;
	} probe_t;

endpackage

>>> src/sdd_cell.sv
`timescale 1ns / 1ps
module sdd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load_en,
	input  logic [sdd_pkg::VAL_W-1:0]     load_value,
	input  logic                          cell_valid,
	input  logic [sdd_pkg::IDX_W-1:0]     cell_idx,
	input  logic                          row_b,
	input  sdd_pkg::probe_t               probe_i,
	output sdd_pkg::probe_t               probe_o,
	output logic [sdd_pkg::VAL_W-1:0]     stored
);
	import sdd_pkg::*;

	logic [VAL_W-1:0] value_q;
	logic             pvalid_q;
	logic             pfrom_b_q;
	logic [IDX_W-1:0] pidx_q;
	logic [VAL_W-1:0] pvalue_q;
	logic             pkill_q;
	logic             same_row;
	logic             hit;

	always_ff @(posedge clk) begin
		if (load_en) begin
			value_q <= load_value;
		end
	end

	// same row: only earlier entries mark a duplicate; other row: any entry is a hit
	assign same_row = (probe_i.from_b == row_b);
	assign hit = probe_i.valid && cell_valid && (value_q == probe_i.value)
		&& (!same_row || (cell_idx < probe_i.idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= 1'b0;
		end else begin
			pvalid_q <= probe_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		pfrom_b_q <= probe_i.from_b;
		pidx_q    <= probe_i.idx;
		pvalue_q  <= probe_i.value;
		pkill_q   <= probe_i.kill | hit;
	end

	assign probe_o = {pvalid_q, pfrom_b_q, pidx_q, pvalue_q, pkill_q};
	assign stored  = value_q;

endmodule

>>> src/symmetric_difference_dedup.sv
`timescale 1ns / 1ps
// channel  | ports                        | handshake
// ---------+------------------------------+------------------------------------
// command  | cmd (req_type, value)        | taken when start high, busy low
// result   | result (value, flags)        | result_valid strobe, one cycle each
//
// A load does not raise busy; the next item may follow at once.
// A finish holds busy while every stored element runs as a probe through the row
// of DEPTH_A + DEPTH_B cells, one cell a cycle. The last item is on the ports in
// the same cycle that busy falls.
// Reset clears counts, overflow flag and control; stored values are not cleared.
// Results cannot be stalled by the receiver.
module symmetric_difference_dedup #(
	parameter int DEPTH_A = sdd_pkg::DEF_DEPTH_A,
	parameter int DEPTH_B = sdd_pkg::DEF_DEPTH_B
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sdd_pkg::cmd_t    cmd,
	output logic             result_valid,
	output sdd_pkg::result_t result
);
	import sdd_pkg::*;

	localparam int CHAIN = DEPTH_A + DEPTH_B;
	localparam int A_IW = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
	localparam int B_IW = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_a_q;
	logic [CNT_W-1:0] cnt_b_q;
	logic             ovf_q;
	logic [CNT_W-1:0] idx_q;
	logic             phase_b_q;
	logic             held_valid_q;
	logic [VAL_W-1:0] held_value_q;
	logic             result_valid_q;
	result_t          result_q;

	probe_t           chain [CHAIN+1];
	logic [CHAIN-1:0] chain_vld;
	logic [VAL_W-1:0] a_vals [DEPTH_A];
	logic [VAL_W-1:0] b_vals [DEPTH_B];

	logic             accept;
	logic             load_a;
	logic             load_b;
	logic             issue_a;
	logic             issue_b;
	logic             exit_keep;
	logic             drain_done;
	logic [VAL_W-1:0] head_value;

	assign accept = start && !busy;
	assign load_a = accept && (cmd.req_type == REQ_LOAD_A) && (cnt_a_q < CNT_W'(DEPTH_A));
	assign load_b = accept && (cmd.req_type == REQ_LOAD_B) && (cnt_b_q < CNT_W'(DEPTH_B));
	assign issue_a = (state_q == ST_ISSUE) && !phase_b_q && (idx_q < cnt_a_q);
	assign issue_b = (state_q == ST_ISSUE) && phase_b_q && (idx_q < cnt_b_q);

	assign head_value = phase_b_q ? b_vals[idx_q[B_IW-1:0]] : a_vals[idx_q[A_IW-1:0]];
	assign chain[0] = {issue_a || issue_b, phase_b_q, idx_q[IDX_W-1:0], head_value, 1'b0};

	genvar k;
	generate
		for (k = 0; k < CHAIN; k++) begin : g_cell
			if (k < DEPTH_A) begin : g_a
				sdd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.load_en    (load_a && (cnt_a_q == CNT_W'(k))),
					.load_value (cmd.value),
					.cell_valid (CNT_W'(k) < cnt_a_q),
					.cell_idx   (IDX_W'(k)),
					.row_b      (1'b0),
					.probe_i    (chain[k]),
					.probe_o    (chain[k+1]),
					.stored     (a_vals[k])
				);
			end else begin : g_b
				sdd_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.load_en    (load_b && (cnt_b_q == CNT_W'(k - DEPTH_A))),
					.load_value (cmd.value),
					.cell_valid (CNT_W'(k - DEPTH_A) < cnt_b_q),
					.cell_idx   (IDX_W'(k - DEPTH_A)),
					.row_b      (1'b1),
					.probe_i    (chain[k]),
					.probe_o    (chain[k+1]),
					.stored     (b_vals[k - DEPTH_A])
				);
			end
			assign chain_vld[k] = chain[k+1].valid;
		end
	endgenerate

	assign exit_keep = chain[CHAIN].valid && !chain[CHAIN].kill;
	assign drain_done = (state_q == ST_DRAIN) && !(|chain_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_a_q        <= '0;
			cnt_b_q        <= '0;
			ovf_q          <= 1'b0;
			idx_q          <= '0;
			phase_b_q      <= 1'b0;
			held_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.req_type)
							REQ_LOAD_A: begin
								if (load_a) cnt_a_q <= cnt_a_q + 1'b1;
								else ovf_q <= 1'b1;
							end
							REQ_LOAD_B: begin
								if (load_b) cnt_b_q <= cnt_b_q + 1'b1;
								else ovf_q <= 1'b1;
							end
							REQ_FINISH: begin
								state_q      <= ST_ISSUE;
								idx_q        <= '0;
								phase_b_q    <= 1'b0;
								held_valid_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ISSUE: begin
					if (issue_a || issue_b) begin
						idx_q <= idx_q + 1'b1;
					end else if (!phase_b_q) begin
						phase_b_q <= 1'b1;
						idx_q     <= '0;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q        <= ST_IDLE;
						cnt_a_q        <= '0;
						cnt_b_q        <= '0;
						ovf_q          <= 1'b0;
						held_valid_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// hold the newest survivor, release the previous one
			if (exit_keep) begin
				held_valid_q <= 1'b1;
			end
			result_valid_q <= drain_done || (exit_keep && held_valid_q);
		end
	end

	always_ff @(posedge clk) begin
		if (exit_keep) begin
			held_value_q <= chain[CHAIN].value;
		end
		if (exit_keep && held_valid_q) begin
			result_q.result_value <= held_value_q;
			result_q.is_empty     <= 1'b0;
			result_q.overflowed   <= ovf_q;
			result_q.last_of_run  <= 1'b0;
		end else if (drain_done) begin
			result_q.result_value <= held_valid_q ? held_value_q : '0;
			result_q.is_empty     <= !held_valid_q;
			result_q.overflowed   <= ovf_q;
			result_q.last_of_run  <= 1'b1;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
